// ===== sv/psf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG Sub filter package
// Shared constants, codes and types of the Sub filter scanline block.
// ----------------------------------------------------------------------------
package psf_pkg;

  // PNG filter type byte for the Sub filter
  localparam logic [7:0] PngFilterSub = 8'd1;

  // Row geometry
  localparam int MaxRowPixels = 4096;
  localparam int RowPixW      = 13;
  localparam int PosW         = 15;
  localparam int RowBytesW    = 16;

  // Configuration port
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  // Queue between front and back
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDE_SAMPLES = 2'd0,
    CFG_ROW_PIXELS   = 2'd1
  } psf_cfg_idx_e;

  // Back end sequencer
  typedef enum logic [1:0] {
    BK_LEAD = 2'd0,  // next entry, filter type byte first if a row opens
    BK_HIGH = 2'd1,  // type byte sent, emit the first data byte
    BK_LOW  = 2'd2   // emit the held low byte of a 16-bit sample
  } psf_back_state_e;

  // Configuration seen by the front and back
  typedef struct packed {
    logic               wide;
    logic [RowPixW-1:0] row_pixels;
  } psf_cfg_t;

  // One queued item: the current byte and, for a 16-bit sample, its held partner
  typedef struct packed {
    logic [7:0] byte_a;
    logic [7:0] byte_b;
    logic       pair;
  } psf_entry_t;

endpackage

// ===== sv/psf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG Sub filter front end
// Accepts raw bytes, pairs the two bytes of a 16-bit sample and queues items.
// ----------------------------------------------------------------------------
module psf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psf_pkg::psf_cfg_t   cfg_i,
  input  logic                restart_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [7:0] pixel_byte
  input  logic                full_i,
  output logic                push_o,
  output psf_pkg::psf_entry_t entry_o
);
  import psf_pkg::*;

  logic       held_valid_q, held_valid_d;
  logic [7:0] held_byte_q;
  logic       accept;
  logic       hold;

  // Classify: first byte of a 16-bit sample is held, everything else is queued
  always_comb begin
    s_axis_tready  = !full_i;
    accept         = s_axis_tvalid && s_axis_tready;
    hold           = cfg_i.wide && !held_valid_q;
    push_o         = accept && !hold;
    entry_o.byte_a = s_axis_tdata;
    entry_o.byte_b = held_byte_q;
    entry_o.pair   = cfg_i.wide;
    held_valid_d   = held_valid_q;
    if (restart_i) begin
      held_valid_d = 1'b0;
    end else if (accept) begin
      held_valid_d = hold;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q <= 1'b0;
    end else begin
      held_valid_q <= held_valid_d;
    end
  end

  // Hold the low byte until its partner arrives
  always_ff @(posedge clk_i) begin
    if (accept && hold) begin
      held_byte_q <= s_axis_tdata;
    end
  end

endmodule

// ===== sv/psf_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG Sub filter queue
// Short register queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module psf_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  psf_pkg::psf_entry_t entry_i,
  output logic                full_o,
  output logic                head_valid_o,
  output psf_pkg::psf_entry_t head_o,
  input  logic                pop_i
);
  import psf_pkg::*;

  psf_entry_t          mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] count_q, count_d;

  // Advance pointers and occupancy
  always_comb begin
    full_o       = (count_q == FifoCntW'(FifoDepth));
    head_valid_o = (count_q != '0);
    head_o       = mem_q[rd_ptr_q];
    wr_ptr_d     = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d     = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d      = count_q + FifoCntW'(push_i) - FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth))
    else $error("queue occupancy exceeds its depth");

endmodule

// ===== sv/psf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG Sub filter back end
// Emits the filter type byte and the Sub differences against the left pixel.
// ----------------------------------------------------------------------------
module psf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  psf_pkg::psf_cfg_t   cfg_i,
  input  logic                restart_i,
  input  logic                head_valid_i,
  input  psf_pkg::psf_entry_t head_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // [7:0] out_byte
  output logic                m_axis_tlast,  // row_end
  output logic [1:0]          m_axis_tuser   // [0] row_start, [1] run_last
);
  import psf_pkg::*;

  psf_back_state_e      state_q, state_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [7:0]           left_q [8];
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_byte_q, out_byte_d;
  logic                 row_start_q, row_start_d;
  logic                 row_end_q, row_end_d;
  logic                 run_last_q, run_last_d;

  logic                 fire;
  logic                 emit_type;
  logic                 write_left;
  logic [RowPixW-1:0]   pix_eff;
  logic [RowBytesW-1:0] row_bytes;
  logic [RowBytesW-1:0] pos_inc;
  logic                 last;
  logic [2:0]           idx;
  logic                 first_pixel;
  logic [7:0]           raw;
  logic [7:0]           left;

  // Row length in bytes, pixels clamped to the legal range
  always_comb begin
    pix_eff = cfg_i.row_pixels;
    if (cfg_i.row_pixels == '0) begin
      pix_eff = RowPixW'(1);
    end else if (cfg_i.row_pixels > RowPixW'(MaxRowPixels)) begin
      pix_eff = RowPixW'(MaxRowPixels);
    end
    row_bytes = cfg_i.wide ? {pix_eff, 3'b000} : {1'b0, pix_eff, 2'b00};
  end

  // Left neighbor lookup and end of row
  always_comb begin
    pos_inc     = {1'b0, pos_q} + RowBytesW'(1);
    last        = (pos_inc >= row_bytes);
    idx         = cfg_i.wide ? pos_q[2:0] : {1'b0, pos_q[1:0]};
    first_pixel = (pos_q[PosW-1:3] == '0) && (cfg_i.wide || !pos_q[2]);
    raw         = (state_q == BK_LOW) ? head_i.byte_b : head_i.byte_a;
    left        = first_pixel ? 8'd0 : left_q[idx];
  end

  // Sequencer: next state and output register load
  always_comb begin
    fire        = head_valid_i && (!out_valid_q || m_axis_tready);
    emit_type   = (state_q == BK_LEAD) && (pos_q == '0);
    state_d     = state_q;
    pos_d       = pos_q;
    pop_o       = 1'b0;
    write_left  = 1'b0;
    out_valid_d = m_axis_tready ? 1'b0 : out_valid_q;
    out_byte_d  = out_byte_q;
    row_start_d = row_start_q;
    row_end_d   = row_end_q;
    run_last_d  = run_last_q;
    if (restart_i) begin
      state_d = BK_LEAD;
      pos_d   = '0;
    end else if (fire) begin
      out_valid_d = 1'b1;
      if (emit_type) begin
        out_byte_d  = PngFilterSub;
        row_start_d = 1'b1;
        row_end_d   = 1'b0;
        run_last_d  = 1'b0;
        state_d     = BK_HIGH;
      end else begin
        write_left  = 1'b1;
        out_byte_d  = raw - left;
        row_start_d = 1'b0;
        row_end_d   = last;
        run_last_d  = (state_q == BK_LOW) || !head_i.pair;
        pos_d       = last ? '0 : pos_inc[PosW-1:0];
        unique case (state_q)
          BK_LEAD, BK_HIGH: begin
            if (head_i.pair) begin
              state_d = BK_LOW;
            end else begin
              state_d = BK_LEAD;
              pop_o   = 1'b1;
            end
          end
          BK_LOW: begin
            state_d = BK_LEAD;
            pop_o   = 1'b1;
          end
          default: begin
            state_d = BK_LEAD;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_LEAD;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload and left pixel line
  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    row_start_q <= row_start_d;
    row_end_q   <= row_end_d;
    run_last_q  <= run_last_d;
    if (write_left) begin
      left_q[idx] <= raw;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = row_end_q;
  assign m_axis_tuser  = {run_last_q, row_start_q};

  a_low_has_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_LOW |-> head_valid_i && head_i.pair)
    else $error("low byte step without a paired entry at the queue head");

  a_high_at_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_HIGH |-> pos_q == '0)
    else $error("type byte sent away from the start of a row");

  a_type_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && row_start_q |->
      out_byte_q == PngFilterSub && !row_end_q && !run_last_q)
    else $error("row start result is not a bare filter type byte");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> head_valid_i)
    else $error("pop from an empty queue");

endmodule

// ===== sv/png_sub_filter_scanline.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PNG Sub filter scanline stage
// Turns a stream of RGBA image bytes into PNG scanlines filtered with Sub.
// ----------------------------------------------------------------------------
// Takes one raw byte per cycle while the queue has room and returns one
// result per cycle while the output is taken. Each row opens with the
// filter type byte, so a row-opening byte gives two results in 8-bit mode;
// in 16-bit mode the first byte of a sample gives none and the second
// gives two or three. The output register, one transaction per cycle, sets
// the sustained rate: one result per input byte plus a type byte per row,
// and a four-entry queue absorbs the extra results so input rarely stalls.
// Input is queued, then registered at the output. Writing either register
// restarts the row and drops a held byte; write them only while idle.
// ----------------------------------------------------------------------------
module png_sub_filter_scanline (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [psf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [psf_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] pixel_byte
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [7:0]                   m_axis_tdata,  // [7:0] out_byte
  output logic                         m_axis_tlast,  // row_end
  output logic [1:0]                   m_axis_tuser   // [0] row_start, [1] run_last
);
  import psf_pkg::*;

  psf_cfg_t   cfg_q, cfg_d;
  logic       restart;
  logic       push;
  logic       full;
  logic       head_valid;
  logic       pop;
  psf_entry_t entry;
  psf_entry_t head;

  // Decode register writes; any known register restarts the row
  always_comb begin
    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_WIDE_SAMPLES: begin
          cfg_d.wide = cfg_data_i[0];
          restart    = 1'b1;
        end
        CFG_ROW_PIXELS: begin
          cfg_d.row_pixels = cfg_data_i[RowPixW-1:0];
          restart          = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wide       <= 1'b0;
      cfg_q.row_pixels <= RowPixW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  psf_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .restart_i     (restart),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (entry)
  );

  psf_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  psf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .restart_i     (restart),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
